FILE: rtl/rmmt_pkg.sv
// shared constants for the running mean and second moment table
// no dependencies
package rmmt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int CFG_W  = 5;
   localparam int VAL_W  = 32;
   localparam int MOM_W  = 64;
   localparam int CNT_W  = 32;
   localparam int LIM_W  = 9;
   localparam int STEP_W = 7;

   localparam logic [CFG_W-1:0]  CFG_RESET       = 5'd16;
   localparam logic [STEP_W-1:0] MEAN_DIV_STEPS  = 7'd32;
   localparam logic [STEP_W-1:0] MOM_DIV_STEPS   = 7'd64;

endpackage

FILE: rtl/rmmt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module rmmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/running_mean_moment_table_core.sv
// running mean and mean-of-squares table with a shared multiplier and divider
// depends on rmmt_pkg and rmmt_ram
//
// usage:
//  - req_* is a valid/ready channel carrying one table element per beat; elements
//    of a run address entries 0, 1, ... and the run ends on req_last or after
//    entries_in_use elements. the first element of a run updates the counts.
//  - rsp_* is a valid/ready channel returning one beat per request beat: the
//    entry index, its updated mean, mean of squares, 0/1 flag and the counts.
//  - csr_wr_en/csr_wr_data write entries_in_use; write only while idle.
//  - each element goes through table read, a 32-step mean division and a
//    64-step moment division that run one quotient bit per cycle on the shared
//    divider, four passes through the shared 32x32 multiplier and write back.
//    a division whose quotient overflows is skipped, and elements that leave
//    the entry unchanged go from table read straight to write back.
//  - req_ready is high only while the sequencer is idle.
//  - the result sits in an output register; a stalled rsp side still lets the
//    next request be taken, and only the write-back step waits for the slot.
//  - reset clears counts, run position, the table (through per-entry valid
//    bits, so no clearing pass) and sets entries_in_use to 16.
module running_mean_moment_table_core #(
   parameter int TABLE_DEPTH = rmmt_pkg::TABLE_DEPTH_DEF,
   parameter int FRAC_BITS   = rmmt_pkg::FRAC_BITS_DEF,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_wr_en,
   input  logic [rmmt_pkg::CFG_W-1:0]   csr_wr_data,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic                         req_success,
   input  logic signed [31:0]           req_sample_value,
   input  logic [31:0]                  req_other_total,
   input  logic [31:0]                  req_other_successes,
   input  logic signed [31:0]           req_other_mean,
   input  logic [63:0]                  req_other_moment,
   input  logic                         req_other_binary,
   input  logic                         req_last,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [IDX_W-1:0]             rsp_entry_index,
   output logic signed [31:0]           rsp_mean_out,
   output logic [63:0]                  rsp_moment_out,
   output logic                         rsp_binary_out,
   output logic [31:0]                  rsp_total_out,
   output logic [31:0]                  rsp_successes_out
);

   import rmmt_pkg::*;

   localparam int ROW_W = 1 + MOM_W + VAL_W;
   localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_LOAD  = 10'b00_0000_0010,
      S_SQR   = 10'b00_0000_0100,
      S_PREP  = 10'b00_0000_1000,
      S_MDIV  = 10'b00_0001_0000,
      S_MLO   = 10'b00_0010_0000,
      S_MHI   = 10'b00_0100_0000,
      S_VDIV  = 10'b00_1000_0000,
      S_VFIN  = 10'b01_0000_0000,
      S_WRITE = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] entries_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] succ_ff, succ_in;
   logic [CNT_W-1:0] weight_ff, weight_in;
   logic [TABLE_DEPTH-1:0] valid_ff;

   // latched request
   logic              mode_ff, success_ff, obin_ff;
   logic [VAL_W-1:0]  x_ff, omean_ff;
   logic [MOM_W-1:0]  omom_ff;
   logic [IDX_W-1:0]  e_ff;

   // datapath
   logic [VAL_W-1:0]  cur_mean_ff, mean_new_ff, mean_new_in, mean_mag_ff, abs_x_ff, w_ff;
   logic [MOM_W-1:0]  cur_mom_ff, mom_new_ff, mom_new_in, tgt_mom_ff, mom_mag_ff, p0_ff;
   logic              mean_up_ff, mom_up_ff, flag_new_ff, ovf_ff;
   logic [31:0]       rem_ff, rem_in;
   logic [63:0]       dvd_ff, dvd_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   // output register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [VAL_W-1:0]  rsp_mean_ff;
   logic [MOM_W-1:0]  rsp_mom_ff;
   logic              rsp_bin_ff;
   logic [CNT_W-1:0]  rsp_total_ff, rsp_succ_ff;

   logic              accept;
   logic [LIM_W-1:0]  limit, e_inc;
   logic [IDX_W-1:0]  e_cur;
   logic              first;
   logic [CNT_W:0]    tot_sum, succ_sum;
   logic [ROW_W-1:0]  rd_row, wr_row;
   logic              wr_en;
   logic [VAL_W-1:0]  row_mean, ld_tgt, ld_mag;
   logic [MOM_W-1:0]  row_mom, vd_mag;
   logic              row_flag, ld_up;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p, p1;
   logic [32:0]       div_t;
   logic              div_ge;
   logic [31:0]       div_r;
   logic [VAL_W-1:0]  mean_q;
   logic [MOM_W-1:0]  mom_q;
   logic              out_free;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // run position
   always_comb begin
      if (entries_ff == '0) begin
         limit = LIM_W'(1);
      end else if (LIM_W'(entries_ff) > LIM_W'(TABLE_DEPTH)) begin
         limit = LIM_W'(TABLE_DEPTH);
      end else begin
         limit = LIM_W'(entries_ff);
      end
      e_cur = (LIM_W'(idx_ff) >= limit) ? '0 : idx_ff;
      first = (e_cur == '0);
      e_inc = LIM_W'(e_cur) + LIM_W'(1);
      idx_in = (req_last || e_inc >= limit) ? '0 : e_inc[IDX_W-1:0];
   end

   // saturating counts
   always_comb begin
      total_in  = total_ff;
      succ_in   = succ_ff;
      weight_in = weight_ff;
      if (req_mode) begin
         tot_sum  = {1'b0, total_ff} + {1'b0, req_other_total};
         succ_sum = {1'b0, succ_ff} + {1'b0, req_other_successes};
      end else begin
         tot_sum  = {1'b0, total_ff} + (CNT_W+1)'(1);
         succ_sum = {1'b0, succ_ff} + (CNT_W+1)'(req_success);
      end
      if (first) begin
         total_in = tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
         succ_in  = succ_sum[CNT_W] ? '1 : succ_sum[CNT_W-1:0];
         if (req_mode) begin
            weight_in = req_other_successes;
         end
      end
   end

   rmmt_ram #(
      .WIDTH(ROW_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(e_ff),
      .wr_data(wr_row),
      .rd_en  (accept),
      .rd_addr(e_cur),
      .rd_data(rd_row)
   );

   assign wr_en  = (state_ff == S_WRITE) && out_free;
   assign wr_row = {flag_new_ff, mom_new_ff, mean_new_ff};

   // entry read, never-written entries read as reset value
   always_comb begin
      if (valid_ff[e_ff]) begin
         row_mean = rd_row[VAL_W-1:0];
         row_mom  = rd_row[VAL_W +: MOM_W];
         row_flag = rd_row[ROW_W-1];
      end else begin
         row_mean = '0;
         row_mom  = '0;
         row_flag = 1'b1;
      end
      ld_tgt = mode_ff ? omean_ff : x_ff;
      ld_up  = $signed(ld_tgt) >= $signed(row_mean);
      ld_mag = ld_up ? (ld_tgt - row_mean) : (row_mean - ld_tgt);
      vd_mag = (tgt_mom_ff >= cur_mom_ff) ? (tgt_mom_ff - cur_mom_ff)
                                          : (cur_mom_ff - tgt_mom_ff);
   end

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         S_SQR: begin
            mul_a = abs_x_ff;
            mul_b = abs_x_ff;
         end
         S_PREP: begin
            mul_a = w_ff;
            mul_b = mean_mag_ff;
         end
         S_MLO: begin
            mul_a = w_ff;
            mul_b = mom_mag_ff[31:0];
         end
         default: begin
            mul_a = w_ff;
            mul_b = mom_mag_ff[63:32];
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);
   assign p1    = mul_p + {32'd0, p0_ff[63:32]};

   // shared restoring divider step
   assign div_t  = {rem_ff, dvd_ff[63]};
   assign div_ge = div_t >= {1'b0, succ_ff};
   assign div_r  = div_ge ? 32'(div_t - {1'b0, succ_ff}) : div_t[31:0];

   assign mean_q = (ovf_ff || dvd_ff[31:0] > mean_mag_ff) ? mean_mag_ff : dvd_ff[31:0];
   assign mom_q  = (ovf_ff || dvd_ff > mom_mag_ff) ? mom_mag_ff : dvd_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      cnt_in      = cnt_ff;
      mean_new_in = mean_new_ff;
      mom_new_in  = mom_new_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            mean_new_in = row_mean;
            mom_new_in  = row_mom;
            if (succ_ff == '0 || (!mode_ff && !success_ff)) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            rem_in = mul_p[63:32];
            dvd_in = {mul_p[31:0], 32'd0};
            cnt_in = MEAN_DIV_STEPS;
            state_in = (mul_p[63:32] >= succ_ff) ? S_MLO : S_MDIV;
         end
         S_MDIV: begin
            rem_in = div_r;
            dvd_in = {dvd_ff[62:0], div_ge};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            mean_new_in = mean_up_ff ? (cur_mean_ff + mean_q) : (cur_mean_ff - mean_q);
            state_in = S_MHI;
         end
         S_MHI: begin
            rem_in = p1[63:32];
            dvd_in = {p1[31:0], p0_ff[31:0]};
            cnt_in = MOM_DIV_STEPS;
            state_in = (p1[63:32] >= succ_ff) ? S_VFIN : S_VDIV;
         end
         S_VDIV: begin
            rem_in = div_r;
            dvd_in = {dvd_ff[62:0], div_ge};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               state_in = S_VFIN;
            end
         end
         S_VFIN: begin
            mom_new_in = mom_up_ff ? (cur_mom_ff + mom_q) : (cur_mom_ff - mom_q);
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entries_ff   <= CFG_RESET;
         idx_ff       <= '0;
         total_ff     <= '0;
         succ_ff      <= '0;
         weight_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            entries_ff <= csr_wr_data;
         end
         if (accept) begin
            idx_ff    <= idx_in;
            total_ff  <= total_in;
            succ_ff   <= succ_in;
            weight_ff <= weight_in;
         end
         if (wr_en) begin
            valid_ff[e_ff] <= 1'b1;
         end
         if (wr_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      mean_new_ff <= mean_new_in;
      mom_new_ff  <= mom_new_in;
      if (accept) begin
         mode_ff    <= req_mode;
         success_ff <= req_success;
         x_ff       <= req_sample_value;
         omean_ff   <= req_other_mean;
         omom_ff    <= req_other_moment;
         obin_ff    <= req_other_binary;
         e_ff       <= e_cur;
      end
      if (state_ff == S_LOAD) begin
         cur_mean_ff <= row_mean;
         cur_mom_ff  <= row_mom;
         mean_mag_ff <= ld_mag;
         mean_up_ff  <= ld_up;
         abs_x_ff    <= x_ff[VAL_W-1] ? (VAL_W'(0) - x_ff) : x_ff;
         w_ff        <= mode_ff ? weight_ff : VAL_W'(1);
         if (mode_ff) begin
            flag_new_ff <= row_flag && obin_ff;
         end else if (success_ff) begin
            flag_new_ff <= row_flag && (x_ff == '0 || x_ff == ONE_VAL);
         end else begin
            flag_new_ff <= row_flag;
         end
      end
      if (state_ff == S_SQR) begin
         tgt_mom_ff <= mode_ff ? omom_ff : mul_p;
      end
      if (state_ff == S_PREP) begin
         mom_mag_ff <= vd_mag;
         mom_up_ff  <= tgt_mom_ff >= cur_mom_ff;
         ovf_ff     <= mul_p[63:32] >= succ_ff;
      end
      if (state_ff == S_MLO) begin
         p0_ff <= mul_p;
      end
      if (state_ff == S_MHI) begin
         ovf_ff <= p1[63:32] >= succ_ff;
      end
      if (wr_en) begin
         rsp_idx_ff   <= e_ff;
         rsp_mean_ff  <= mean_new_ff;
         rsp_mom_ff   <= mom_new_ff;
         rsp_bin_ff   <= flag_new_ff;
         rsp_total_ff <= total_ff;
         rsp_succ_ff  <= succ_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_index   = rsp_idx_ff;
   assign rsp_mean_out      = rsp_mean_ff;
   assign rsp_moment_out    = rsp_mom_ff;
   assign rsp_binary_out    = rsp_bin_ff;
   assign rsp_total_out     = rsp_total_ff;
   assign rsp_successes_out = rsp_succ_ff;

   // remainder stays below the divisor while dividing
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MDIV || state_ff == S_VDIV) |-> rem_ff < succ_ff)
      else $error("divider remainder not below success count");

   // counts never decrease across a beat
   a_counts_monotonic: assert property (@(posedge clock) disable iff (reset)
      ($past(accept) && !$past(reset)) |->
         (succ_ff >= $past(succ_ff) && total_ff >= $past(total_ff)))
      else $error("saturating count decreased");

   // a result appears only from write-back
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WRITE))
      else $error("response raised outside write-back");

endmodule
